// ----- src/hse_pkg.sv -----
`timescale 1ns / 1ps
package hse_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IPAD_LOAD,
    ST_BLK_RUN,
    ST_FIN_PREP,
    ST_FIN_RUN,
    ST_INNER_DONE,
    ST_OPAD_RUN,
    ST_OUTER_RUN,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ABSORB
  } hmac_phase_t;

  typedef struct packed {
    logic start;
    logic init_iv;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam logic [7:0]  IPAD     = 8'h36;
  localparam logic [7:0]  OPAD     = 8'h5c;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [63:0] PAD_BITS = 64'd512;
  localparam logic [63:0] OUT_BITS = 64'd768;
  localparam int unsigned LEN_POS  = 56;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ----- src/hse_round.sv -----
`timescale 1ns / 1ps
// One SHA-256 compression run: a single round unit reused for every round,
// with a 16-word message schedule window.
module hse_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hse_pkg::core_ctl_t    ctl,
  input  logic [511:0]          block,
  input  logic [255:0]          hash_in,
  output logic [255:0]          hash_out,
  output hse_pkg::core_sts_t    sts
);

  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [255:0] base_r;
  logic [511:0] w_r;
  logic [5:0]   rnd_r;
  logic         busy_r, done_r;

  logic [31:0] wt, s0, s1, wn, t1, t2, ch, maj, ep0, ep1;
  logic [255:0] base_sel;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  always_comb begin
    wt  = w_r[511:480];
    s0  = rotr(w_r[479:448], 7) ^ rotr(w_r[479:448], 18) ^ (w_r[479:448] >> 3);
    s1  = rotr(w_r[63:32], 17) ^ rotr(w_r[63:32], 19) ^ (w_r[63:32] >> 10);
    wn  = wt + s0 + w_r[223:192] + s1;
    ep1 = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    ch  = (e_r & f_r) ^ (~e_r & g_r);
    t1  = h_r + ep1 + ch + hse_pkg::round_k(rnd_r) + wt;
    ep0 = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    maj = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2  = ep0 + maj;
    base_sel = ctl.init_iv ? hse_pkg::INIT_HASH : hash_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r) begin
      base_r <= base_sel;
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= base_sel;
      w_r <= block;
    end else if (busy_r) begin
      w_r <= {w_r[479:0], wn};
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
  end

  assign hash_out = {base_r[255:224] + a_r, base_r[223:192] + b_r,
                     base_r[191:160] + c_r, base_r[159:128] + d_r,
                     base_r[127:96] + e_r, base_r[95:64] + f_r,
                     base_r[63:32] + g_r, base_r[31:0] + h_r};
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ----- src/hmac_sha256_engine_core.sv -----
`timescale 1ns / 1ps
// A byte that fills a block holds the input for one compression, other bytes
// need none; the first item of a message adds a compression of the inner pad
// block; a last item adds 3 or 4 compressions plus the sequencing states between.
// Rate is set by the single round unit, one SHA-256 round per cycle.
// Reset (synchronous, active low) clears the key registers, the sequencer and
// the output valid; the block and digest buffers carry no reset.
module hmac_sha256_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word_0,
  output logic [63:0] out_digest_word_1,
  output logic [63:0] out_digest_word_2,
  output logic [63:0] out_digest_word_3,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // Key registers, one 64-bit word each at byte address 8*i.
  logic [63:0] key_r [8];
  logic [2:0]  cfg_idx;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = key_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      key_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // The key block is assembled flat and XORed with the chosen pad byte.
  logic [511:0] key_flat;
  always_comb begin
    for (int i = 0; i < 8; i++) key_flat[511 - 64*i -: 64] = key_r[i];
  end

  hse_pkg::seq_state_t state_r, state_nxt;
  hse_pkg::hmac_phase_t phase_r, phase_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [255:0] chain_r, chain_nxt;
  logic [255:0] inner_r, inner_nxt;
  logic [255:0] dig_r, dig_nxt;
  logic         fin2_r, fin2_nxt;   // a second padding block is still to come
  logic         last_r, last_nxt;
  logic         ov_r, ov_nxt;

  hse_pkg::core_ctl_t ctl;
  hse_pkg::core_sts_t sts;
  logic [511:0] blk;
  logic [255:0] hash_out;

  hse_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .block(blk),
    .hash_in(chain_r), .hash_out(hash_out), .sts(sts)
  );

  logic in_acc;
  assign in_stall = (state_r != hse_pkg::ST_IDLE) || ov_r;
  assign in_acc   = in_valid && !in_stall;

  // Padding of a partly filled buffer: 0x80 after the data, zeros, and the
  // length in the last eight bytes when it fits.
  function automatic logic [511:0] pad_block(input logic [511:0] b, input logic [5:0] n,
                                             input logic [63:0] bits, input logic len_ok);
    logic [511:0] r;
    r = b;
    for (int i = 0; i < 64; i++) begin
      if (i == n) r[511 - 8*i -: 8] = hse_pkg::PAD_BYTE;
      else if (i > n) r[511 - 8*i -: 8] = 8'h00;
    end
    if (len_ok) r[63:0] = bits;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    chain_nxt = chain_r;
    inner_nxt = inner_r;
    dig_nxt   = dig_r;
    fin2_nxt  = fin2_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r && out_stall;
    ctl       = '0;
    blk       = buf_r;
    unique case (state_r)
      hse_pkg::ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last;
          if (in_byte_present) begin
            buf_nxt[511 - 8*cnt_r[5:0] -: 8] = in_data_byte;
            cnt_nxt  = cnt_r + 7'd1;
            bits_nxt = bits_r + 64'd8;
          end
          if (phase_r != hse_pkg::PH_ABSORB) begin
            // First item of a message: the byte lands in slot 0 and the inner pad
            // block is absorbed before any data block.
            cnt_nxt  = in_byte_present ? 7'd1 : 7'd0;
            bits_nxt = hse_pkg::PAD_BITS + (in_byte_present ? 64'd8 : 64'd0);
            if (in_byte_present) buf_nxt[511:504] = in_data_byte;
            phase_nxt = hse_pkg::PH_ABSORB;
            state_nxt = hse_pkg::ST_IPAD_LOAD;
          end else if (in_byte_present && cnt_r == 7'd63) begin
            state_nxt = hse_pkg::ST_BLK_RUN;
          end else if (in_last) begin
            state_nxt = hse_pkg::ST_FIN_PREP;
          end
        end
      end
      hse_pkg::ST_IPAD_LOAD: begin
        ctl.start   = 1'b1;
        ctl.init_iv = 1'b1;
        blk = key_flat ^ {64{hse_pkg::IPAD}};
        state_nxt = hse_pkg::ST_BLK_RUN;
        if (cnt_r == 7'd64) cnt_nxt = cnt_r;
      end
      hse_pkg::ST_BLK_RUN: begin
        // A data block starts on entry when the buffer is full.
        if (!sts.busy && !sts.done && cnt_r == 7'd64) begin
          ctl.start = 1'b1;
          cnt_nxt = 7'd0;
        end else if (sts.done) begin
          chain_nxt = hash_out;
          state_nxt = last_r ? hse_pkg::ST_FIN_PREP : hse_pkg::ST_IDLE;
        end
      end
      hse_pkg::ST_FIN_PREP: begin
        // Two blocks when 0x80 lands past byte 55.
        fin2_nxt = (cnt_r[5:0] >= 6'(hse_pkg::LEN_POS));
        buf_nxt  = pad_block(buf_r, cnt_r[5:0], bits_r, cnt_r[5:0] < 6'(hse_pkg::LEN_POS));
        state_nxt = hse_pkg::ST_FIN_RUN;
      end
      hse_pkg::ST_FIN_RUN: begin
        if (!sts.busy && !sts.done) ctl.start = 1'b1;
        else if (sts.done) begin
          chain_nxt = hash_out;
          if (fin2_r) begin
            fin2_nxt = 1'b0;
            buf_nxt  = {448'h0, bits_r};
          end else begin
            state_nxt = hse_pkg::ST_INNER_DONE;
          end
        end
      end
      hse_pkg::ST_INNER_DONE: begin
        inner_nxt = chain_r;
        ctl.start   = 1'b1;
        ctl.init_iv = 1'b1;
        blk = key_flat ^ {64{hse_pkg::OPAD}};
        state_nxt = hse_pkg::ST_OPAD_RUN;
      end
      hse_pkg::ST_OPAD_RUN: begin
        if (sts.done) begin
          chain_nxt = hash_out;
          buf_nxt   = {inner_r, hse_pkg::PAD_BYTE, 184'h0, hse_pkg::OUT_BITS};
          state_nxt = hse_pkg::ST_OUTER_RUN;
        end
      end
      hse_pkg::ST_OUTER_RUN: begin
        if (!sts.busy && !sts.done) ctl.start = 1'b1;
        else if (sts.done) begin
          dig_nxt   = hash_out;
          state_nxt = hse_pkg::ST_EMIT;
        end
      end
      hse_pkg::ST_EMIT: begin
        ov_nxt    = 1'b1;
        phase_nxt = hse_pkg::PH_IDLE;
        cnt_nxt   = '0;
        bits_nxt  = '0;
        state_nxt = hse_pkg::ST_IDLE;
      end
      default: state_nxt = hse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hse_pkg::ST_IDLE;
      phase_r <= hse_pkg::PH_IDLE;
      cnt_r   <= '0;
      bits_r  <= '0;
      fin2_r  <= 1'b0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      fin2_r  <= fin2_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r   <= buf_nxt;
    chain_r <= chain_nxt;
    inner_r <= inner_nxt;
    dig_r   <= dig_nxt;
  end

  assign out_valid         = ov_r;
  assign out_digest_word_0 = dig_r[255:192];
  assign out_digest_word_1 = dig_r[191:128];
  assign out_digest_word_2 = dig_r[127:64];
  assign out_digest_word_3 = dig_r[63:0];

  // No request is taken while a digest waits.
  a_no_acc_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while digest pending");

  // A digest only appears straight after the emit step.
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == hse_pkg::ST_EMIT)
    else $error("digest raised outside emit");

  // The round unit is never started from the pad-load states while it is busy.
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !(state_r == hse_pkg::ST_IPAD_LOAD || state_r == hse_pkg::ST_INNER_DONE))
    else $error("round unit restarted while busy");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  // Stimulus and checking run against a local bit-true model of HMAC-SHA-256.
  // Every digest that leaves the block is compared word by word with the
  // oldest digest that the model has predicted.

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } hmac_req_t;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word_0, out_digest_word_1, out_digest_word_2, out_digest_word_3;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  hmac_sha256_engine_core dut (.*);

  always #5 clk = ~clk;

  // Model state: the key copy and the inner hash in progress.
  logic [63:0]           key_copy [8];
  logic [255:0]          running_hash;
  logic [511:0]          pending_block;
  int unsigned           pending_bytes;
  logic [63:0]           bit_length;
  hse_pkg::hmac_phase_t  msg_phase;
  logic [255:0]          digest_queue [$];

  int  error_count = 0;
  int  hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
  bit  hold_done = 1'b0;  // the long hold-off has been started
  bit  calm = 1'b0;       // no idling on either side while set
  int  items_sent = 0;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, hh} = h;
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {h[255:224] + a, h[223:192] + b, h[191:160] + c, h[159:128] + d,
            h[127:96] + e, h[95:64] + f, h[63:32] + g, h[31:0] + hh};
  endfunction

  // Standard SHA-256 tail: 0x80, zero fill, 64-bit big-endian length.
  function automatic logic [255:0] sha_pad_finish(input logic [255:0] h, input logic [511:0] blk,
                                                  input int unsigned n, input logic [63:0] bits);
    logic [255:0] acc;
    acc = h;
    n = n & 63;
    blk[511 - 8 * n -: 8] = 8'h80;
    n++;
    for (int i = n; i < 64; i++) blk[511 - 8 * i -: 8] = 8'h00;
    if (n > 56) begin
      acc = sha_compress(acc, blk);
      blk = '0;
    end
    blk[63:0] = bits;
    return sha_compress(acc, blk);
  endfunction

  function automatic logic [511:0] key_block(input logic [7:0] pad);
    return {key_copy[0], key_copy[1], key_copy[2], key_copy[3],
            key_copy[4], key_copy[5], key_copy[6], key_copy[7]} ^ {64{pad}};
  endfunction

  // Advances the model by one accepted request and queues any digest it yields.
  task automatic absorb_request(input hmac_req_t r);
    logic [255:0] inner, outer;
    if (msg_phase != hse_pkg::PH_ABSORB) begin
      running_hash = sha_compress(SHA_IV, key_block(8'h36));
      pending_bytes = 0;
      bit_length = 64'd512;
      msg_phase = hse_pkg::PH_ABSORB;
    end
    if (r.byte_present) begin
      pending_block[511 - 8 * pending_bytes -: 8] = r.data_byte;
      pending_bytes++;
      bit_length += 64'd8;
      if (pending_bytes == 64) begin
        running_hash = sha_compress(running_hash, pending_block);
        pending_bytes = 0;
      end
    end
    if (r.last) begin
      inner = sha_pad_finish(running_hash, pending_block, pending_bytes, bit_length);
      outer = sha_compress(SHA_IV, key_block(8'h5c));
      outer = sha_pad_finish(outer, {inner, 256'd0}, 32, 64'd768);
      digest_queue.push_back(outer);
      running_hash = SHA_IV;
      pending_bytes = 0;
      bit_length = '0;
      msg_phase = hse_pkg::PH_IDLE;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %016h expected %016h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Offers one request from a rising edge and returns at the edge that takes it, or after the idle gap that follows.
  // Valid is dropped only when an idle gap follows, so it never toggles twice in a step.
  task automatic send_request(input hmac_req_t r);
    in_valid <= 1'b1;
    in_data_byte <= r.data_byte;
    in_byte_present <= r.byte_present;
    in_last <= r.last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    absorb_request(r);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Setup and access phase of one APB write; the register takes the data at
  // the access edge. The caller closes the transfer after the last write.
  task automatic write_key(input int idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 6'(8 * idx);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    key_copy[idx] = value;
  endtask

  // Keys change only once every digest is out and the block has settled.
  task automatic load_key(input int mode);
    logic [63:0] v;
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = '0;
        1: v = '1;
        2: v = (i < 2) ? {$urandom, $urandom} : 64'd0;  // short key, zero padded
        default: v = {$urandom, $urandom};
      endcase
      write_key(i, v);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Receiver: random stalls, an occasional long hold-off, and the digest check.
  always @(posedge clk) begin
    logic [255:0] want;
    if (out_valid && !out_stall && rst_n) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected digest", out_digest_word_0, 64'd0);
      end else begin
        want = digest_queue.pop_front();
        if (out_digest_word_0 !== want[255:192])
          report_mismatch("digest_word_0", out_digest_word_0, want[255:192]);
        if (out_digest_word_1 !== want[191:128])
          report_mismatch("digest_word_1", out_digest_word_1, want[191:128]);
        if (out_digest_word_2 !== want[127:64])
          report_mismatch("digest_word_2", out_digest_word_2, want[127:64]);
        if (out_digest_word_3 !== want[63:0])
          report_mismatch("digest_word_3", out_digest_word_3, want[63:0]);
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && items_sent >= 100) begin
      // Block fills and must stall its input.
      hold_cycles <= 400;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 37);
    end
  end

  // Directed requests: empty message, single-byte extremes, a leading empty
  // request, a trailing empty last, and a short text message.
  hmac_req_t directed [19] = '{
    '{8'h00, 1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b1},
    '{8'hff, 1'b1, 1'b1},
    '{8'haa, 1'b0, 1'b0}, '{8'h55, 1'b1, 1'b1},
    '{8'h61, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0}, '{8'h63, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1},
    '{8'h01, 1'b1, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b0}, '{8'h7f, 1'b1, 1'b1},
    '{8'hff, 1'b1, 1'b0}, '{8'hff, 1'b1, 1'b0}, '{8'hff, 1'b1, 1'b0}, '{8'hff, 1'b1, 1'b1},
    '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1}
  };

  initial begin
    hmac_req_t r;
    int len, msgs, mode;
    for (int i = 0; i < 8; i++) key_copy[i] = '0;
    running_hash = SHA_IV;
    pending_block = '0;
    pending_bytes = 0;
    bit_length = '0;
    msg_phase = hse_pkg::PH_IDLE;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset key (all zero) first, then all ones, then a short key.
    for (mode = 0; mode < 3; mode++) begin
      if (mode != 0) load_key(mode);
      foreach (directed[i]) send_request(directed[i]);
    end

    // Random part: mostly short messages, some near block boundaries, a few long.
    msgs = 0;
    while (items_sent < 450) begin
      if (msgs % 8 == 7) load_key((msgs % 32 == 31) ? 1 : 3);
      calm = (msgs >= 12 && msgs < 18);
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(54, 66);
        2:       len = $urandom_range(118, 130);
        default: len = $urandom_range(0, 10);
      endcase
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = '{8'($urandom), 1'b0, 1'b0};    // no-op request inside the stream
          send_request(r);
        end
        r = '{8'($urandom), 1'b1, 1'b0};
        if (b == len - 1 && $urandom_range(0, 1)) r.last = 1'b1;
        send_request(r);
      end
      if (len == 0 || !r.last) begin
        r = '{8'($urandom), 1'($urandom), 1'b1};
        send_request(r);
      end
      msgs++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (digest_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("hmac_sha256_engine_core regression: pass");
    end else begin
      $display("hmac_sha256_engine_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("hmac_sha256_engine_core regression: fail");
    $finish;
  end

endmodule
